// File: design/banked_register_allocator_defines.svh
// Assertion macros used by the register allocator RTL.
`ifndef BANKED_REGISTER_ALLOCATOR_DEFINES_SVH
`define BANKED_REGISTER_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define BRA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define BRA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define BRA_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/bra_pkg.sv
`default_nettype none

package bra_pkg;

    localparam int REGS_PER_CLASS_DEF = 16;
    localparam int RESERVED_FLOOR_DEF = 4;
    localparam int NUM_CLASSES        = 3;
    localparam int CLASS_W            = 2;
    localparam int FLAT_W             = 6;
    localparam int LOCAL_W            = 4;
    localparam int WIDE_W             = 8;

    localparam logic [CLASS_W-1:0] CLS_UNSIGNED = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SIGNED   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_FLOAT    = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_INVALID  = 2'd3;

    typedef enum logic [1:0] {
        ACT_ALLOC      = 2'd0,
        ACT_FREE       = 2'd1,
        ACT_CLEAR_TAKE = 2'd2,
        ACT_DECODE     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_USED  = 3'd2,
        ST_RANGE     = 3'd3,
        ST_BAD_CLASS = 3'd4
    } status_t;

    typedef struct packed {
        action_t             action;
        logic [CLASS_W-1:0]  register_class;
        logic [FLAT_W-1:0]   flat_number;
    } request_t;

    typedef struct packed {
        logic [FLAT_W-1:0]   given_number;
        logic [CLASS_W-1:0]  found_class;
        logic [LOCAL_W-1:0]  local_index;
        status_t             status;
    } result_t;

endpackage

`default_nettype wire

// File: design/bra_ram.sv
`default_nettype none

module bra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/bra_exec.sv
`default_nettype none

module bra_exec #(
    parameter int REGS_PER_CLASS = bra_pkg::REGS_PER_CLASS_DEF,
    parameter int RESERVED_FLOOR = bra_pkg::RESERVED_FLOOR_DEF,
    parameter int IDX_W          = $clog2(REGS_PER_CLASS)
) (
    input  wire bra_pkg::action_t                    action,
    input  wire logic [bra_pkg::CLASS_W-1:0]         register_class,
    input  wire logic                                dec_ok,
    input  wire logic [bra_pkg::CLASS_W-1:0]         dec_cls,
    input  wire logic [IDX_W-1:0]                    dec_idx,
    input  wire logic [REGS_PER_CLASS-1:0]           map_word,
    output logic                                     wr_en,
    output logic      [REGS_PER_CLASS-1:0]           wr_data,
    output bra_pkg::result_t                         result
);

    localparam int WW = bra_pkg::WIDE_W;

    logic [REGS_PER_CLASS-1:0] search_map;
    logic [IDX_W-1:0]          free_idx;
    logic                      free_found;
    logic [bra_pkg::CLASS_W-1:0] alloc_cls;
    logic [WW-1:0]             alloc_flat;
    logic [WW-1:0]             free_idx_wide;
    logic [WW-1:0]             dec_idx_wide;

    always_comb
    begin
        search_map = (action == bra_pkg::ACT_CLEAR_TAKE) ? '0 : map_word;
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < REGS_PER_CLASS; i++)
        begin
            if (i > RESERVED_FLOOR && !search_map[i])
            begin
                free_idx   = IDX_W'(i);
                free_found = 1'b1;
            end
        end
    end

    assign alloc_cls     = (action == bra_pkg::ACT_CLEAR_TAKE) ? bra_pkg::CLS_UNSIGNED
                                                               : register_class;
    assign free_idx_wide = WW'(free_idx);
    assign dec_idx_wide  = WW'(dec_idx);
    assign alloc_flat    = WW'(WW'(alloc_cls) * WW'(REGS_PER_CLASS)) + free_idx_wide;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_data = search_map;
        result  = '{given_number: '0, found_class: '0, local_index: '0,
                    status: bra_pkg::ST_OK};
        unique case (action)
            bra_pkg::ACT_ALLOC, bra_pkg::ACT_CLEAR_TAKE:
            begin
                wr_en = (action == bra_pkg::ACT_CLEAR_TAKE);
                if (action == bra_pkg::ACT_ALLOC && register_class == bra_pkg::CLS_INVALID)
                begin
                    result.status = bra_pkg::ST_BAD_CLASS;
                end
                else if (!free_found)
                begin
                    result.status = bra_pkg::ST_FULL;
                end
                else
                begin
                    wr_en                = 1'b1;
                    wr_data              = search_map | (REGS_PER_CLASS'(1) << free_idx);
                    result.given_number  = alloc_flat[bra_pkg::FLAT_W-1:0];
                    result.found_class   = alloc_cls;
                    result.local_index   = free_idx_wide[bra_pkg::LOCAL_W-1:0];
                end
            end
            bra_pkg::ACT_FREE:
            begin
                if (!dec_ok)
                begin
                    result.status = bra_pkg::ST_RANGE;
                end
                else
                begin
                    result.found_class = dec_cls;
                    result.local_index = dec_idx_wide[bra_pkg::LOCAL_W-1:0];
                    if (map_word[dec_idx])
                    begin
                        wr_en   = 1'b1;
                        wr_data = map_word & ~(REGS_PER_CLASS'(1) << dec_idx);
                    end
                    else
                    begin
                        result.status = bra_pkg::ST_NOT_USED;
                    end
                end
            end
            bra_pkg::ACT_DECODE:
            begin
                if (!dec_ok)
                begin
                    result.status = bra_pkg::ST_RANGE;
                end
                else
                begin
                    result.found_class = dec_cls;
                    result.local_index = dec_idx_wide[bra_pkg::LOCAL_W-1:0];
                end
            end
            default:
            begin
                result.status = bra_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/banked_register_allocator.sv
// Register allocator with one in-use bitmap per register class.
// A request carries an action, a class and a flat register number; each
// request produces exactly one result with the allocated number, the decoded
// class and index, and a status code.
// Both channels use valid/ready. The block takes a request whenever it is
// idle, even while an earlier result still waits in the output register.
// The bitmap memory is read at the accepting edge; the priority search and
// write-back follow in the execute state, which a stalled output can hold.
// The block takes no new request until the read-modify-write of the bitmap
// memory is done.
// If the receiver stalls, the finished result is held in the output register
// and a following request waits in its execute cycle until the slot frees.
// Reset clears all valid bits, so every register of every class reads as
// free without a memory clearing pass. Clear-and-take also empties all
// classes at once through those valid bits.

`default_nettype none

`include "banked_register_allocator_defines.svh"

module banked_register_allocator #(
    parameter int REGS_PER_CLASS = bra_pkg::REGS_PER_CLASS_DEF,
    parameter int RESERVED_FLOOR = bra_pkg::RESERVED_FLOOR_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              request_valid,
    output logic                   request_ready,
    input  wire bra_pkg::request_t request,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output bra_pkg::result_t       result
);

    localparam int IDX_W = $clog2(REGS_PER_CLASS);
    localparam int AW    = $clog2(bra_pkg::NUM_CLASSES);
    localparam int WW    = bra_pkg::WIDE_W;
    localparam logic [WW-1:0] BASE1 = WW'(REGS_PER_CLASS);
    localparam logic [WW-1:0] BASE2 = WW'(2 * REGS_PER_CLASS);
    localparam logic [WW-1:0] LIMIT = WW'(3 * REGS_PER_CLASS);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [bra_pkg::NUM_CLASSES-1:0] valid_reg, valid_next;
    bra_pkg::request_t              req_reg;
    logic                           dec_ok_reg;
    logic [bra_pkg::CLASS_W-1:0]    dec_cls_reg;
    logic [IDX_W-1:0]               dec_idx_reg;
    logic [AW-1:0]                  addr_reg;
    logic                           out_valid_reg;
    bra_pkg::result_t               out_reg;

    logic                           accept;
    logic                           slot_free;
    logic                           fire;
    logic [WW-1:0]                  flat_wide;
    logic [WW-1:0]                  base;
    logic [WW-1:0]                  idx_wide;
    logic                           dec_ok;
    logic [bra_pkg::CLASS_W-1:0]    dec_cls;
    logic [AW-1:0]                  rd_addr;
    logic [REGS_PER_CLASS-1:0]      rd_data;
    logic [REGS_PER_CLASS-1:0]      map_word;
    logic                           wr_en;
    logic [REGS_PER_CLASS-1:0]      wr_data;
    bra_pkg::result_t               exec_result;

    assign request_ready = (state_reg == S_IDLE);
    assign accept        = request_valid && request_ready;
    assign slot_free     = !out_valid_reg || result_ready;
    assign fire          = (state_reg == S_EXEC) && slot_free;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;

    always_comb
    begin
        flat_wide = WW'(request.flat_number);
        dec_ok    = (flat_wide < LIMIT);
        if (flat_wide >= BASE2)
        begin
            dec_cls = bra_pkg::CLS_FLOAT;
            base    = BASE2;
        end
        else if (flat_wide >= BASE1)
        begin
            dec_cls = bra_pkg::CLS_SIGNED;
            base    = BASE1;
        end
        else
        begin
            dec_cls = bra_pkg::CLS_UNSIGNED;
            base    = '0;
        end
        idx_wide = flat_wide - base;
        unique case (request.action)
            bra_pkg::ACT_ALLOC:
            begin
                rd_addr = (request.register_class == bra_pkg::CLS_INVALID)
                        ? AW'(bra_pkg::CLS_UNSIGNED) : AW'(request.register_class);
            end
            bra_pkg::ACT_FREE, bra_pkg::ACT_DECODE:
            begin
                rd_addr = AW'(dec_cls);
            end
            bra_pkg::ACT_CLEAR_TAKE:
            begin
                rd_addr = AW'(bra_pkg::CLS_UNSIGNED);
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    bra_ram #(
        .WIDTH (REGS_PER_CLASS),
        .DEPTH (bra_pkg::NUM_CLASSES)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (fire && wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_data),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign map_word = valid_reg[addr_reg] ? rd_data : '0;

    bra_exec #(
        .REGS_PER_CLASS (REGS_PER_CLASS),
        .RESERVED_FLOOR (RESERVED_FLOOR),
        .IDX_W          (IDX_W)
    ) u_exec (
        .action         (req_reg.action),
        .register_class (req_reg.register_class),
        .dec_ok         (dec_ok_reg),
        .dec_cls        (dec_cls_reg),
        .dec_idx        (dec_idx_reg),
        .map_word       (map_word),
        .wr_en          (wr_en),
        .wr_data        (wr_data),
        .result         (exec_result)
    );

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                    if (req_reg.action == bra_pkg::ACT_CLEAR_TAKE)
                    begin
                        valid_next = '0;
                    end
                    if (wr_en)
                    begin
                        valid_next[addr_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= request;
            dec_ok_reg  <= dec_ok;
            dec_cls_reg <= dec_cls;
            dec_idx_reg <= idx_wide[IDX_W-1:0];
            addr_reg    <= rd_addr;
        end
        if (fire)
        begin
            out_reg <= exec_result;
        end
    end

    `BRA_ASSERT_NXT(a_accept_to_exec, clk, rst_n, accept, state_reg == S_EXEC)
    `BRA_ASSERT_NXT(a_fire_to_result, clk, rst_n, fire, out_valid_reg)
    `BRA_ASSERT_NXT(a_stall_holds_exec, clk, rst_n,
        (state_reg == S_EXEC) && !slot_free, state_reg == S_EXEC)
    `BRA_ASSERT_NXT(a_alloc_marks_valid, clk, rst_n,
        fire && wr_en && (req_reg.action == bra_pkg::ACT_ALLOC), valid_reg[addr_reg])

endmodule

`default_nettype wire
